>>> rtl/gis_pkg.sv
// gis_pkg: word types and constants shared by the gamepad input scanner
package gis_pkg;

	localparam int SUM_W    = 15;
	localparam int OFFSET_W = 12;
	localparam int DRIFT_W  = 15;
	localparam int TICKS_W  = 16;
	localparam int HELD_W   = 32;
	localparam int DPAD_W   = 4;
	localparam int BTN_W    = 13;
	localparam int MASK_W   = BTN_W + DPAD_W;
	localparam int AXIS_W   = 16;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	localparam logic [2:0] REG_OFFSET_X        = 3'd0;
	localparam logic [2:0] REG_OFFSET_Y        = 3'd1;
	localparam logic [2:0] REG_DRIFT_BAND      = 3'd2;
	localparam logic [2:0] REG_PRESS_TICKS     = 3'd3;
	localparam logic [2:0] REG_LONG_TICKS      = 3'd4;
	localparam logic [2:0] REG_VERY_LONG_TICKS = 3'd5;
	localparam logic [2:0] REG_DPAD_AS_BUTTONS = 3'd6;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_PRESS     = 3'd1;
	localparam logic [2:0] EV_LONG      = 3'd2;
	localparam logic [2:0] EV_VERY_LONG = 3'd3;
	localparam logic [2:0] EV_RELEASE   = 3'd4;

	localparam logic [1:0] LED_OFF    = 2'd0;
	localparam logic [1:0] LED_FAST   = 2'd1;
	localparam logic [1:0] LED_MEDIUM = 2'd2;
	localparam logic [1:0] LED_SLOW   = 2'd3;

	localparam logic [3:0] HAT_CENTRE     = 4'd0;
	localparam logic [3:0] HAT_UP         = 4'd1;
	localparam logic [3:0] HAT_UP_RIGHT   = 4'd2;
	localparam logic [3:0] HAT_RIGHT      = 4'd3;
	localparam logic [3:0] HAT_DOWN_RIGHT = 4'd4;
	localparam logic [3:0] HAT_DOWN       = 4'd5;
	localparam logic [3:0] HAT_DOWN_LEFT  = 4'd6;
	localparam logic [3:0] HAT_LEFT       = 4'd7;
	localparam logic [3:0] HAT_UP_LEFT    = 4'd8;

	typedef struct packed {
		logic [SUM_W-1:0]  x_sum;
		logic [SUM_W-1:0]  y_sum;
		logic [DPAD_W-1:0] dpad_levels;
		logic [BTN_W-1:0]  button_levels;
		logic              key_down;
		logic              link_up;
	} tick_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] x_report;
		logic signed [AXIS_W-1:0] y_report;
		logic                     x_moved;
		logic                     y_moved;
		logic [3:0]               hat_code;
		logic [MASK_W-1:0]        press_mask;
		logic [MASK_W-1:0]        release_mask;
		logic                     send_report;
		logic [2:0]               mgmt_event;
		logic [1:0]               led_pattern;
	} result_t;

endpackage

>>> rtl/gis_axis_scale.sv
// gis_axis_scale: piecewise scaling of one joystick sample sum to a signed axis value
module gis_axis_scale (
	input  logic [gis_pkg::SUM_W-1:0]           sum,
	input  logic [gis_pkg::OFFSET_W-1:0]        offset,
	output logic signed [gis_pkg::AXIS_W-1:0]   scaled
);

	logic [16:0]        v;
	logic [29:0]        prod_lo;
	logic [12:0]        q_lo;
	logic signed [18:0] d_lo;
	logic [16:0]        n_hi;
	logic [29:0]        prod_hi;
	logic [15:0]        q0_hi;
	logic [15:0]        r_hi;
	logic [15:0]        q_hi;
	logic [18:0]        h_hi;

	assign v = {2'b00, sum} + {2'b00, offset, 3'b000};

	// lower branch: v*7000/16384 - 7000, times eight
	assign prod_lo = 30'(v) * 30'd7000;
	assign q_lo    = prod_lo[26:14];
	assign d_lo    = $signed({3'b000, q_lo, 3'b000}) - 19'sd56000;

	// upper branch: (v-16385)*5000/16383, division by 2^14-1 with one correction
	assign n_hi    = v - 17'd16385;
	assign prod_hi = 30'(n_hi) * 30'd5000;
	assign q0_hi   = prod_hi[29:14];
	assign r_hi    = {2'b00, prod_hi[13:0]} + q0_hi;
	assign q_hi    = (r_hi >= 16'd16383) ? q0_hi + 16'd1 : q0_hi;
	assign h_hi    = {q_hi, 3'b000};

	always_comb begin
		if (v <= 17'd16384) begin
			if (d_lo < -19'sd32767) begin
				scaled = -16'sd32767;
			end else begin
				scaled = d_lo[15:0];
			end
		end else begin
			if (h_hi > 19'd32767) begin
				scaled = 16'sd32767;
			end else begin
				scaled = h_hi[15:0];
			end
		end
	end

endmodule

>>> rtl/gamepad_input_scanner.sv
// gamepad_input_scanner: poll tick processing for joystick, d-pad, buttons and management key
// Usage:
//   tick channel (tick_valid/tick_ready/tick) carries one poll word per tick: two joystick
//   sample sums, d-pad and button levels, management button level and link state.
//   rep channel (rep_valid/rep_ready/rep) returns one report word per tick word, in order.
//   The APB-style port sets the offsets, drift deadband, hold thresholds and d-pad mode;
//   write it only while no word is in flight.
// Pipeline and throughput:
//   three register stages: input register, scaled axis register, report register.
//   A report word is registered in the report register after its tick word passes the
//   input and scaled axis registers; one word per cycle is sustained while rep_ready is high,
//   set by the single pass through the axis scaler and the state update.
// Reset:
//   arst_n clears the pipeline, the last axis, d-pad and button levels, the hold counter
//   and the LED mode; registers return to their documented defaults.
// Stall:
//   while rep_ready is low the report word holds; earlier stages keep filling empty
//   slots, so up to two more tick words are taken before tick_ready drops.
module gamepad_input_scanner #(
	parameter int NUM_BUTTONS = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_valid,
	output logic                          tick_ready,
	input  gis_pkg::tick_t                tick,
	output logic                          rep_valid,
	input  logic                          rep_ready,
	output gis_pkg::result_t              rep,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gis_pkg::ADDR_W-1:0]    paddr,
	input  logic [gis_pkg::DATA_W-1:0]    pwdata,
	output logic [gis_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	logic [gis_pkg::OFFSET_W-1:0] offset_x_q, offset_y_q;
	logic [gis_pkg::DRIFT_W-1:0]  drift_band_q;
	logic [gis_pkg::TICKS_W-1:0]  press_ticks_q, long_ticks_q, very_long_ticks_q;
	logic                         dpad_as_buttons_q;

	logic                         cfg_wr;
	logic [2:0]                   cfg_idx;

	logic                         v_s1, v_s2, v_s3;
	logic                         rdy1, rdy2, rdy3;
	gis_pkg::tick_t               tick_s1, tick_s2;
	logic signed [gis_pkg::AXIS_W-1:0] cx_s2, cy_s2;
	logic signed [gis_pkg::AXIS_W-1:0] cx_c, cy_c;
	gis_pkg::result_t             rep_s3;

	logic signed [gis_pkg::AXIS_W-1:0] last_x_q, last_y_q;
	logic [gis_pkg::DPAD_W-1:0]   last_dpad_q;
	logic [gis_pkg::BTN_W-1:0]    last_buttons_q;
	logic [gis_pkg::HELD_W-1:0]   held_q;
	logic                         was_pressed_q;
	logic [1:0]                   led_q;

	logic [gis_pkg::BTN_W-1:0]    btn_mask;
	logic [gis_pkg::BTN_W-1:0]    btn, bch;
	logic [gis_pkg::DPAD_W-1:0]   dch;
	logic signed [17:0]           x_lo, x_hi, y_lo, y_hi;
	logic                         xm, ym, changed;
	logic [gis_pkg::HELD_W-1:0]   held_inc, held_d;
	logic                         was_pressed_d;
	logic [2:0]                   ev;
	logic [1:0]                   led_d;
	logic [3:0]                   hat;
	gis_pkg::result_t             res_c;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q        <= '0;
			offset_y_q        <= '0;
			drift_band_q      <= 15'd100;
			press_ticks_q     <= 16'd5;
			long_ticks_q      <= 16'd300;
			very_long_ticks_q <= 16'd1000;
			dpad_as_buttons_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				gis_pkg::REG_OFFSET_X:        offset_x_q        <= pwdata[11:0];
				gis_pkg::REG_OFFSET_Y:        offset_y_q        <= pwdata[11:0];
				gis_pkg::REG_DRIFT_BAND:      drift_band_q      <= pwdata[14:0];
				gis_pkg::REG_PRESS_TICKS:     press_ticks_q     <= pwdata[15:0];
				gis_pkg::REG_LONG_TICKS:      long_ticks_q      <= pwdata[15:0];
				gis_pkg::REG_VERY_LONG_TICKS: very_long_ticks_q <= pwdata[15:0];
				gis_pkg::REG_DPAD_AS_BUTTONS: dpad_as_buttons_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			gis_pkg::REG_OFFSET_X:        prdata = {20'd0, offset_x_q};
			gis_pkg::REG_OFFSET_Y:        prdata = {20'd0, offset_y_q};
			gis_pkg::REG_DRIFT_BAND:      prdata = {17'd0, drift_band_q};
			gis_pkg::REG_PRESS_TICKS:     prdata = {16'd0, press_ticks_q};
			gis_pkg::REG_LONG_TICKS:      prdata = {16'd0, long_ticks_q};
			gis_pkg::REG_VERY_LONG_TICKS: prdata = {16'd0, very_long_ticks_q};
			gis_pkg::REG_DPAD_AS_BUTTONS: prdata = {31'd0, dpad_as_buttons_q};
			default:                      prdata = '0;
		endcase
	end

	// pipeline handshake
	assign rdy3       = !v_s3 || rep_ready;
	assign rdy2       = !v_s2 || rdy3;
	assign rdy1       = !v_s1 || rdy2;
	assign tick_ready = rdy1;
	assign rep_valid  = v_s3;
	assign rep        = rep_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= tick_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// stage 1: input word
	always_ff @(posedge clk) begin
		if (tick_valid && rdy1) begin
			tick_s1 <= tick;
		end
	end

	// stage 2: scaled axes
	gis_axis_scale u_scale_x (
		.sum    (tick_s1.x_sum),
		.offset (offset_x_q),
		.scaled (cx_c)
	);

	gis_axis_scale u_scale_y (
		.sum    (tick_s1.y_sum),
		.offset (offset_y_q),
		.scaled (cy_c)
	);

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			tick_s2 <= tick_s1;
			cx_s2   <= cx_c;
			cy_s2   <= cy_c;
		end
	end

	// stage 3: deadband, edge detection, management key timing
	always_comb begin
		for (int i = 0; i < gis_pkg::BTN_W; i++) begin
			btn_mask[i] = (i < NUM_BUTTONS);
		end
	end

	assign x_lo = 18'(cx_s2) - $signed({3'b000, drift_band_q});
	assign x_hi = 18'(cx_s2) + $signed({3'b000, drift_band_q});
	assign y_lo = 18'(cy_s2) - $signed({3'b000, drift_band_q});
	assign y_hi = 18'(cy_s2) + $signed({3'b000, drift_band_q});
	assign xm   = (x_lo > 18'(last_x_q)) || (x_hi < 18'(last_x_q));
	assign ym   = (y_lo > 18'(last_y_q)) || (y_hi < 18'(last_y_q));

	assign btn     = tick_s2.button_levels & btn_mask;
	assign bch     = btn ^ last_buttons_q;
	assign dch     = tick_s2.dpad_levels ^ last_dpad_q;
	assign changed = xm || ym || (|bch) || (|dch);

	always_comb begin
		logic up, down, left, right;
		up    = tick_s2.dpad_levels[0];
		down  = tick_s2.dpad_levels[1];
		left  = tick_s2.dpad_levels[2];
		right = tick_s2.dpad_levels[3];
		if (up && right) begin
			hat = gis_pkg::HAT_UP_RIGHT;
		end else if (down && right) begin
			hat = gis_pkg::HAT_DOWN_RIGHT;
		end else if (down && left) begin
			hat = gis_pkg::HAT_DOWN_LEFT;
		end else if (up && left) begin
			hat = gis_pkg::HAT_UP_LEFT;
		end else if (up) begin
			hat = gis_pkg::HAT_UP;
		end else if (right) begin
			hat = gis_pkg::HAT_RIGHT;
		end else if (down) begin
			hat = gis_pkg::HAT_DOWN;
		end else if (left) begin
			hat = gis_pkg::HAT_LEFT;
		end else begin
			hat = gis_pkg::HAT_CENTRE;
		end
	end

	assign held_inc = held_q + 32'd1;

	always_comb begin
		ev            = gis_pkg::EV_NONE;
		led_d         = led_q;
		held_d        = held_inc;
		was_pressed_d = 1'b1;
		if (!tick_s2.key_down) begin
			held_d        = '0;
			was_pressed_d = 1'b0;
			if (was_pressed_q && (held_q >= {16'd0, press_ticks_q})) begin
				ev    = gis_pkg::EV_RELEASE;
				led_d = gis_pkg::LED_OFF;
			end
		end else if (held_inc == {16'd0, very_long_ticks_q}) begin
			ev    = gis_pkg::EV_VERY_LONG;
			led_d = gis_pkg::LED_SLOW;
		end else if (held_inc == {16'd0, long_ticks_q}) begin
			ev    = gis_pkg::EV_LONG;
			led_d = gis_pkg::LED_MEDIUM;
		end else if (held_inc == {16'd0, press_ticks_q}) begin
			ev    = gis_pkg::EV_PRESS;
			led_d = gis_pkg::LED_FAST;
		end
	end

	always_comb begin
		res_c.x_report     = xm ? cx_s2 : last_x_q;
		res_c.y_report     = ym ? cy_s2 : last_y_q;
		res_c.x_moved      = xm;
		res_c.y_moved      = ym;
		res_c.hat_code     = hat;
		res_c.press_mask   = {dpad_as_buttons_q ? (dch & tick_s2.dpad_levels) : 4'd0,
			bch & btn};
		res_c.release_mask = {dpad_as_buttons_q ? (dch & ~tick_s2.dpad_levels) : 4'd0,
			bch & ~btn};
		res_c.send_report  = changed && tick_s2.link_up;
		res_c.mgmt_event   = ev;
		res_c.led_pattern  = led_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q       <= '0;
			last_y_q       <= '0;
			last_dpad_q    <= '0;
			last_buttons_q <= '0;
			held_q         <= '0;
			was_pressed_q  <= 1'b0;
			led_q          <= gis_pkg::LED_OFF;
		end else if (v_s2 && rdy3) begin
			last_x_q       <= res_c.x_report;
			last_y_q       <= res_c.y_report;
			last_dpad_q    <= tick_s2.dpad_levels;
			last_buttons_q <= btn;
			held_q         <= held_d;
			was_pressed_q  <= was_pressed_d;
			led_q          <= led_d;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			rep_s3 <= res_c;
		end
	end

	// checks
	a_held_implies_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != '0) |-> was_pressed_q)
		else $error("hold counter running with key not down");

	a_press_release_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ((rep_s3.press_mask & rep_s3.release_mask) == '0))
		else $error("same input both pressed and released");

	a_release_led_off: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && (rep_s3.mgmt_event == gis_pkg::EV_RELEASE)) |->
		(rep_s3.led_pattern == gis_pkg::LED_OFF))
		else $error("release event left led on");

	a_led_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (rep_s3.led_pattern == led_q))
		else $error("reported led mode differs from state");

	a_empty_front_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> tick_ready)
		else $error("input stalled with empty input register");

endmodule
